// ----- hw/rtl/msd_pkg.sv -----
// Shared types, constants and the digit pattern table of the seven-segment driver.
`default_nettype none

package msd_pkg;

    localparam int DIGIT_COUNT = 4;
    localparam int IDX_W       = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int LINE_COUNT  = (DIGIT_COUNT < 4) ? DIGIT_COUNT : 4;

    // x / 10 == (x * 0xCCCD) >> 19 for every 16-bit x
    localparam logic [15:0] RECIP_TEN   = 16'hCCCD;
    localparam int          RECIP_SHIFT = 19;

    localparam logic [7:0] BLANK_PATTERN = 8'h00;
    localparam int         DP_BIT        = 7;

    localparam logic [1:0] CFG_SCAN_BY_SEGMENT     = 2'd0;
    localparam logic [1:0] CFG_SEGMENT_ACTIVE_HIGH = 2'd1;
    localparam logic [1:0] CFG_DIGIT_ACTIVE_HIGH   = 2'd2;

    typedef enum logic [1:0] {
        ACT_NUMBER = 2'd0,
        ACT_FIELD  = 2'd1,
        ACT_SCAN   = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_POINT,
        ST_SCAN,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] value;
        logic [3:0]  comma;
        logic [3:0]  position;
        logic [3:0]  amount;
    } cmd_item_t;

    typedef struct packed {
        logic [7:0] segment_lines;
        logic [3:0] digit_lines;
        logic [2:0] scan_index;
    } res_item_t;

    function automatic logic [7:0] seg_pattern(input logic [3:0] d);
        logic [7:0] p;
        case (d)
            4'd0:    p = 8'h3F;
            4'd1:    p = 8'h06;
            4'd2:    p = 8'h5B;
            4'd3:    p = 8'h4F;
            4'd4:    p = 8'h66;
            4'd5:    p = 8'h6D;
            4'd6:    p = 8'h7D;
            4'd7:    p = 8'h07;
            4'd8:    p = 8'h7F;
            4'd9:    p = 8'h6F;
            default: p = BLANK_PATTERN;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/multiplexed_seven_segment_driver.sv -----
// Top level: digit buffer, decimal conversion sequencer and display scan drive.
//
//  channel | direction | handshake          | payload
//  cmd     | in        | cmd_valid/cmd_stall | action, value, comma, position, amount
//  res     | out       | res_valid/res_stall | segment_lines, digit_lines, scan_index
//  cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data (always ready)
//
// A number write converts one decimal digit per cycle through the shared divide-by-ten
// reciprocal multiplier, then runs the point and result steps. A formatted write runs the
// same steps for the digits it writes; a scan tick runs the scan and result steps.
// Reset blanks the buffer and sets every segment and digit drive register high.
// A stalled result holds in the output register; the next item may be accepted meanwhile.
`default_nettype none

module multiplexed_seven_segment_driver (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    input  wire msd_pkg::cmd_item_t cmd,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output msd_pkg::res_item_t      res,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic               cfg_data
);
    import msd_pkg::*;

    state_t state_reg, state_next;

    logic conv_en, point_en, scan_en, res_load, cmd_acc, conv_done;

    logic [7:0]       buf_reg [DIGIT_COUNT];
    logic [7:0]       buf_next [DIGIT_COUNT];
    logic [1:0]       act_reg, act_next;
    logic [15:0]      val_reg, val_next;
    logic [3:0]       comma_reg, comma_next;
    logic [IDX_W-1:0] widx_reg, widx_next;
    logic [3:0]       remain_reg, remain_next;
    logic             first_reg, first_next;
    logic [2:0]       scan_cnt_reg, scan_cnt_next;
    logic [2:0]       idx_out_reg, idx_out_next;
    logic [7:0]       seg_drive_reg, seg_drive_next;
    logic [3:0]       dig_drive_reg, dig_drive_next;
    logic             by_seg_reg, seg_high_reg, dig_high_reg;
    logic             res_valid_reg, res_valid_next;
    res_item_t        res_reg;

    // shared divide-by-ten unit
    logic [31:0] prod;
    logic [15:0] quot;
    logic [16:0] quot_ten;
    logic [3:0]  rem;
    logic        keep;
    logic        pos_ok;

    // scan helpers
    logic [2:0] scan_c;
    logic [3:0] scan_c_inc;
    logic [7:0] lit;
    logic [3:0] sel;

    assign prod     = val_reg * RECIP_TEN;
    assign quot     = 16'(prod[31:RECIP_SHIFT]);
    assign quot_ten = {1'b0, quot} + {quot[13:0], 3'b000} + {quot[15:0], 1'b0}
                      - {1'b0, quot};
    assign rem      = 4'(val_reg - quot_ten[15:0]);

    assign cmd_acc   = cmd_valid && !cmd_stall;
    assign pos_ok    = (cmd.position >= 4'd1) && (cmd.position <= 4'(DIGIT_COUNT));
    assign conv_done = (widx_reg == IDX_W'(DIGIT_COUNT - 1)) || (remain_reg == 4'd1);
    assign cfg_ready = 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_acc)
                begin
                    case (cmd.action)
                        ACT_NUMBER: state_next = ST_CONV;
                        ACT_FIELD:
                        begin
                            if (pos_ok && (cmd.amount != 4'd0))
                                state_next = ST_CONV;
                            else
                                state_next = ST_POINT;
                        end
                        ACT_SCAN:   state_next = ST_SCAN;
                        default:    state_next = ST_RESULT;
                    endcase
                end
            end
            ST_CONV:   state_next = conv_done ? ST_POINT : ST_CONV;
            ST_POINT:  state_next = ST_RESULT;
            ST_SCAN:   state_next = ST_RESULT;
            ST_RESULT: state_next = res_load ? ST_IDLE : ST_RESULT;
            default:   state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        cmd_stall = (state_reg != ST_IDLE);
        conv_en   = (state_reg == ST_CONV);
        point_en  = (state_reg == ST_POINT);
        scan_en   = (state_reg == ST_SCAN);
        res_load  = (state_reg == ST_RESULT) && (!res_valid_reg || !res_stall);
    end

    // datapath
    always_comb
    begin
        buf_next       = buf_reg;
        act_next       = act_reg;
        val_next       = val_reg;
        comma_next     = comma_reg;
        widx_next      = widx_reg;
        remain_next    = remain_reg;
        first_next     = first_reg;
        scan_cnt_next  = scan_cnt_reg;
        idx_out_next   = idx_out_reg;
        seg_drive_next = seg_drive_reg;
        dig_drive_next = dig_drive_reg;
        keep           = 1'b0;
        lit            = 8'h00;
        sel            = 4'h0;
        scan_c         = ({1'b0, scan_cnt_reg} >= 4'(DIGIT_COUNT)) ? 3'd0 : scan_cnt_reg;
        scan_c_inc     = {1'b0, scan_c} + 4'd1;

        if (cmd_acc)
        begin
            act_next     = cmd.action;
            val_next     = cmd.value;
            comma_next   = cmd.comma;
            first_next   = 1'b1;
            idx_out_next = scan_cnt_reg;
            if (cmd.action == ACT_FIELD)
            begin
                widx_next   = IDX_W'(cmd.position - 4'd1);
                remain_next = cmd.amount;
            end
            else
            begin
                widx_next   = '0;
                remain_next = 4'(DIGIT_COUNT);
            end
        end

        if (conv_en)
        begin
            if (act_reg == ACT_NUMBER)
                keep = first_reg || (val_reg != 16'd0) || (4'(widx_reg) <= comma_reg);
            else
                keep = first_reg || (val_reg != 16'd0) || (4'(widx_reg) < comma_reg);
            buf_next[widx_reg] = keep ? seg_pattern(rem) : BLANK_PATTERN;
            val_next    = quot;
            first_next  = 1'b0;
            widx_next   = IDX_W'(widx_reg + 1'b1);
            remain_next = remain_reg - 4'd1;
        end

        if (point_en && (comma_reg >= 4'd1) && (comma_reg <= 4'(DIGIT_COUNT)))
            buf_next[IDX_W'(comma_reg - 4'd1)][DP_BIT] = 1'b1;

        if (scan_en)
        begin
            if (by_seg_reg)
            begin
                lit = 8'h01 << scan_cnt_reg;
                for (int j = 0; j < LINE_COUNT; j++)
                    sel[j] = buf_reg[j][scan_cnt_reg];
                idx_out_next  = scan_cnt_reg;
                scan_cnt_next = 3'((scan_cnt_reg + 3'd1) & 3'h7);
            end
            else
            begin
                lit = buf_reg[scan_c[IDX_W-1:0]];
                if ({1'b0, scan_c} < 4'(LINE_COUNT))
                    sel = 4'h1 << scan_c;
                idx_out_next  = scan_c;
                scan_cnt_next = (scan_c_inc >= 4'(DIGIT_COUNT)) ? 3'd0 : scan_c_inc[2:0];
            end
            seg_drive_next = seg_high_reg ? lit : ~lit;
            for (int j = 0; j < LINE_COUNT; j++)
                dig_drive_next[j] = dig_high_reg ? sel[j] : !sel[j];
        end
    end

    always_comb
    begin
        if (res_load)
            res_valid_next = 1'b1;
        else
            res_valid_next = res_valid_reg && res_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            for (int k = 0; k < DIGIT_COUNT; k++)
                buf_reg[k] <= BLANK_PATTERN;
            scan_cnt_reg  <= 3'd0;
            seg_drive_reg <= 8'hFF;
            dig_drive_reg <= 4'hF;
            by_seg_reg    <= 1'b0;
            seg_high_reg  <= 1'b0;
            dig_high_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            buf_reg       <= buf_next;
            scan_cnt_reg  <= scan_cnt_next;
            seg_drive_reg <= seg_drive_next;
            dig_drive_reg <= dig_drive_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SCAN_BY_SEGMENT:     by_seg_reg   <= cfg_data;
                    CFG_SEGMENT_ACTIVE_HIGH: seg_high_reg <= cfg_data;
                    CFG_DIGIT_ACTIVE_HIGH:   dig_high_reg <= cfg_data;
                    default:                 ;
                endcase
            end
        end
    end

    // working registers of the sequencer, no reset needed
    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        val_reg     <= val_next;
        comma_reg   <= comma_next;
        widx_reg    <= widx_next;
        remain_reg  <= remain_next;
        first_reg   <= first_next;
        idx_out_reg <= idx_out_next;
        if (res_load)
        begin
            res_reg.segment_lines <= seg_drive_reg;
            res_reg.digit_lines   <= dig_drive_reg;
            res_reg.scan_index    <= idx_out_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/msd_checker.sv -----
// Port-level checker for the seven-segment driver and its bind.
`default_nettype none

module msd_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               cmd_valid,
    input wire logic               cmd_stall,
    input wire msd_pkg::cmd_item_t cmd,
    input wire logic               res_valid,
    input wire logic               res_stall,
    input wire msd_pkg::res_item_t res
);
    import msd_pkg::*;

    logic [2:0] pending_reg, pending_next;
    logic       cmd_acc, res_acc;

    assign cmd_acc = cmd_valid && !cmd_stall;
    assign res_acc = res_valid && !res_stall;

    // count items accepted but not yet answered
    always_comb
    begin
        pending_next = pending_reg;
        if (cmd_acc && !res_acc)
            pending_next = pending_reg + 3'd1;
        else if (!cmd_acc && res_acc)
            pending_next = pending_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= 3'd0;
        else
            pending_reg <= pending_next;
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_acc |=> cmd_stall)
        else $error("command taken while previous item still in work");

    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (pending_reg != 3'd0))
        else $error("result shown with no item outstanding");

    a_bounded_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd2)
        else $error("more than two items outstanding");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> (res_valid && $stable(res)))
        else $error("stalled result dropped or changed");

endmodule

bind multiplexed_seven_segment_driver msd_checker u_msd_checker (.*);

`default_nettype wire
